// ===== src/lrc_pkg.sv =====
// shared types and constants for the lru result cache
package lrc_pkg;

    localparam int CACHE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_STORE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] ip_key;
        logic [63:0] payload_in;
        logic        resolved;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] payload_out;
        logic        evicted;
        logic [31:0] evicted_key;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_APPEND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             clear;
        logic             vld;
        logic [IDX_W-1:0] idx;
    } scan_ctrl_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_idx;
        logic [63:0]      match_payload;
        logic [IDX_W-1:0] min_idx;
        logic [31:0]      min_key;
    } scan_result_t;

endpackage

// ===== src/lrc_ram.sv =====
// generic single write port, single read port ram with registered read data
module lrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lrc_scan.sv =====
// key match and oldest stamp tracker, fed one entry per cycle
module lrc_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lrc_pkg::scan_ctrl_t  ctrl,
    input  logic [31:0]          req_key,
    input  logic [31:0]          rd_key,
    input  logic [31:0]          rd_stamp,
    input  logic [63:0]          rd_payload,
    output lrc_pkg::scan_result_t result
);
    import lrc_pkg::*;

    logic             found_reg, found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic [63:0]      match_pay_reg, match_pay_next;
    logic [IDX_W-1:0] min_idx_reg, min_idx_next;
    logic [31:0]      min_stamp_reg, min_stamp_next;
    logic [31:0]      min_key_reg, min_key_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        match_idx_reg <= match_idx_next;
        match_pay_reg <= match_pay_next;
        min_idx_reg   <= min_idx_next;
        min_stamp_reg <= min_stamp_next;
        min_key_reg   <= min_key_next;
    end

    always_comb begin
        found_next     = found_reg;
        match_idx_next = match_idx_reg;
        match_pay_next = match_pay_reg;
        min_idx_next   = min_idx_reg;
        min_stamp_next = min_stamp_reg;
        min_key_next   = min_key_reg;
        if (ctrl.clear) begin
            found_next = 1'b0;
        end else if (ctrl.vld) begin
            // first match wins
            if (!found_reg && rd_key == req_key) begin
                found_next     = 1'b1;
                match_idx_next = ctrl.idx;
                match_pay_next = rd_payload;
            end
            // strict compare keeps the lowest index on ties
            if (ctrl.idx == '0 || rd_stamp < min_stamp_reg) begin
                min_idx_next   = ctrl.idx;
                min_stamp_next = rd_stamp;
                min_key_next   = rd_key;
            end
        end
    end

    assign result.found         = found_reg;
    assign result.match_idx     = match_idx_reg;
    assign result.match_payload = match_pay_reg;
    assign result.min_idx       = min_idx_reg;
    assign result.min_key       = min_key_reg;

endmodule

// ===== src/lru_result_cache.sv =====
// lru result cache: each word is checked against every stored entry before its result is valid;
// an unresolved store skips the scan and is ignored, and a store that evicts
// also shifts the entries above the oldest down by one slot and appends the new one at the top
// one word in flight; the next word is taken once the result sits in the output register
// the time per word is set by one read per cycle from the entry rams, over the scan and the shift
// synchronous active-low reset empties the cache at once; entry rams are not cleared
module lru_result_cache (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lrc_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lrc_pkg::rsp_t m_data
);
    import lrc_pkg::*;

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    rsp_t             res_reg, res_next;
    rsp_t             m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             vld_reg, vld_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             issue;
    logic             key_we, pay_we, stamp_we;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_key, wr_stamp;
    logic [63:0]      wr_pay;
    logic [31:0]      rd_key, rd_stamp;
    logic [63:0]      rd_pay;
    scan_ctrl_t       scan_ctrl;
    scan_result_t     scan_res;

    lrc_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (wr_key),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_key)
    );

    lrc_ram #(.WIDTH(64), .DEPTH(CACHE_ENTRIES)) u_pay_ram (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (wr_addr),
        .wdata (wr_pay),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_pay)
    );

    lrc_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_stamp_ram (
        .aclk  (aclk),
        .we    (stamp_we),
        .waddr (wr_addr),
        .wdata (wr_stamp),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_stamp)
    );

    lrc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (scan_ctrl),
        .req_key    (req_reg.ip_key),
        .rd_key     (rd_key),
        .rd_stamp   (rd_stamp),
        .rd_payload (rd_pay),
        .result     (scan_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            vld_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            vld_reg     <= vld_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        rd_cnt_reg <= rd_cnt_next;
        idx_reg    <= idx_next;
    end

    assign issue   = rd_cnt_reg < count_reg;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign scan_ctrl.clear = (state_reg == ST_IDLE) && s_valid;
    assign scan_ctrl.vld   = (state_reg == ST_SCAN) && vld_reg;
    assign scan_ctrl.idx   = idx_reg;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        count_next   = count_reg;
        rd_cnt_next  = rd_cnt_reg;
        vld_next     = 1'b0;
        idx_next     = rd_cnt_reg[IDX_W-1:0];
        key_we       = 1'b0;
        pay_we       = 1'b0;
        stamp_we     = 1'b0;
        wr_addr      = scan_res.match_idx;
        wr_key       = req_reg.ip_key;
        wr_pay       = req_reg.payload_in;
        wr_stamp     = req_reg.now_seconds;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    rd_cnt_next = '0;
                    if (s_data.func == FUNC_STORE && !s_data.resolved) begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    vld_next    = 1'b1;
                end else if (!vld_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_next   = '0;
                state_next = ST_OUT;
                if (scan_res.found) begin
                    res_next.hit = 1'b1;
                    stamp_we     = 1'b1;
                    if (req_reg.func == FUNC_LOOKUP) begin
                        res_next.payload_out = scan_res.match_payload;
                    end else begin
                        pay_we = 1'b1;
                    end
                end else if (req_reg.func == FUNC_STORE) begin
                    if (count_reg == CNT_W'(CACHE_ENTRIES)) begin
                        // full: drop the oldest and close the gap
                        res_next.evicted     = 1'b1;
                        res_next.evicted_key = scan_res.min_key;
                        rd_cnt_next = CNT_W'(scan_res.min_idx) + CNT_W'(1);
                        state_next  = ST_SHIFT;
                    end else begin
                        wr_addr    = count_reg[IDX_W-1:0];
                        key_we     = 1'b1;
                        pay_we     = 1'b1;
                        stamp_we   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_SHIFT: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    vld_next    = 1'b1;
                end
                if (vld_reg) begin
                    wr_addr  = idx_reg - IDX_W'(1);
                    wr_key   = rd_key;
                    wr_pay   = rd_pay;
                    wr_stamp = rd_stamp;
                    key_we   = 1'b1;
                    pay_we   = 1'b1;
                    stamp_we = 1'b1;
                end else if (!issue) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                wr_addr    = IDX_W'(CACHE_ENTRIES - 1);
                key_we     = 1'b1;
                pay_we     = 1'b1;
                stamp_we   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/lru_result_cache_test.sv =====
// testbench for lru_result_cache: random and directed lookups and stores checked against a cache model
`timescale 1ns / 1ps

module lru_result_cache_test;
    import lrc_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 800;
    localparam int SETTLE_WAIT = 200;
    localparam int KEY_POOL_SZ = 128;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    lru_result_cache dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // cache model: entries in insertion order, slots 0 .. model_count-1
    logic [31:0] model_keys     [CACHE_ENTRIES];
    logic [63:0] model_payloads [CACHE_ENTRIES];
    logic [31:0] model_stamps   [CACHE_ENTRIES];
    int          model_count = 0;

    req_t        req_backlog [$];
    rsp_t        rsp_owed [$];
    logic [31:0] key_pool [KEY_POOL_SZ];
    logic [31:0] wall_clock = '0;
    int          fail_count = 0;
    logic        hold_armed = 1'b0;

    function automatic rsp_t cache_access(input req_t r);
        rsp_t res;
        int   found_at;
        int   oldest;
        int   i;
        res      = '0;
        found_at = -1;
        for (i = 0; i < model_count; i++) begin
            if (found_at < 0 && model_keys[i] == r.ip_key) found_at = i;
        end
        if (r.func == FUNC_LOOKUP) begin
            if (found_at >= 0) begin
                model_stamps[found_at] = r.now_seconds;
                res.hit                = 1'b1;
                res.payload_out        = model_payloads[found_at];
            end
        end else if (r.resolved) begin
            if (found_at >= 0) begin
                model_stamps[found_at]   = r.now_seconds;
                model_payloads[found_at] = r.payload_in;
                res.hit                  = 1'b1;
            end else begin
                if (model_count == CACHE_ENTRIES) begin
                    // ties go to the lowest slot
                    oldest = 0;
                    for (i = 1; i < model_count; i++) begin
                        if (model_stamps[i] < model_stamps[oldest]) oldest = i;
                    end
                    res.evicted     = 1'b1;
                    res.evicted_key = model_keys[oldest];
                    for (i = oldest; i + 1 < model_count; i++) begin
                        model_keys[i]     = model_keys[i + 1];
                        model_payloads[i] = model_payloads[i + 1];
                        model_stamps[i]   = model_stamps[i + 1];
                    end
                    model_count--;
                end
                model_keys[model_count]     = r.ip_key;
                model_payloads[model_count] = r.payload_in;
                model_stamps[model_count]   = r.now_seconds;
                model_count++;
            end
        end
        return res;
    endfunction

    task automatic push_req(input logic f, input logic [31:0] key, input logic [63:0] pay,
                            input logic res, input logic [31:0] now);
        req_t r;
        r.func        = f;
        r.ip_key      = key;
        r.payload_in  = pay;
        r.resolved    = res;
        r.now_seconds = now;
        req_backlog = {req_backlog, r};
    endtask

    // mostly keys from a pool so the cache fills, hits and evicts; unresolved stores not counted
    task automatic add_random_reqs(input int n_counted, input int key_span);
        req_t r;
        int   counted;
        counted = 0;
        while (counted < n_counted) begin
            r.func = ($urandom_range(99, 0) < 45) ? FUNC_LOOKUP : FUNC_STORE;
            if (r.func == FUNC_LOOKUP) r.resolved = $urandom_range(1, 0);
            else r.resolved = ($urandom_range(99, 0) < 92);
            if ($urandom_range(99, 0) < 8) r.ip_key = $urandom;
            else r.ip_key = key_pool[$urandom_range(key_span - 1, 0)];
            case ($urandom_range(9, 0))
                0: r.payload_in = '0;
                1: r.payload_in = '1;
                default: r.payload_in = {$urandom, $urandom};
            endcase
            if ($urandom_range(99, 0) < 4) begin
                r.now_seconds = $urandom;
            end else begin
                // small steps give plenty of equal stamps
                wall_clock    = wall_clock + $urandom_range(3, 0);
                r.now_seconds = wall_clock;
            end
            if (r.func == FUNC_LOOKUP || r.resolved) counted++;
            req_backlog = {req_backlog, r};
        end
    endtask

    task automatic wait_drained;
        do @(negedge aclk);
        while (req_backlog.size() != 0 || s_valid || rsp_owed.size() != 0);
    endtask

    initial begin
        for (int i = 0; i < KEY_POOL_SZ; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        push_req(FUNC_LOOKUP, 32'h0000_0000, 64'h0,                   1'b0, 32'h0);
        push_req(FUNC_STORE,  32'h0000_0000, 64'h1234_5678_9ABC_DEF0, 1'b0, 32'h1);
        push_req(FUNC_STORE,  32'h0000_0000, '1,                      1'b1, 32'h0);
        push_req(FUNC_LOOKUP, 32'h0000_0000, '1,                      1'b1, 32'hFFFF_FFFF);
        push_req(FUNC_STORE,  32'hFFFF_FFFF, 64'h0,                   1'b1, 32'hFFFF_FFFF);
        // unresolved store to a present key leaves it untouched
        push_req(FUNC_STORE,  32'h0000_0000, 64'h0000_0000_0000_0123, 1'b0, 32'h7);
        push_req(FUNC_LOOKUP, 32'h0000_0000, 64'h0,                   1'b0, 32'h8);
        push_req(FUNC_STORE,  32'hFFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A, 1'b1, 32'h5);
        push_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 64'h0,                   1'b0, 32'h9);
        push_req(FUNC_LOOKUP, 32'h1234_5678, 64'hDEAD_BEEF_0000_FFFF, 1'b1, 32'hA);
        push_req(FUNC_STORE,  32'h8000_0001, 64'h8000_0000_0000_0001, 1'b1, 32'h8000_0000);
        push_req(FUNC_STORE,  32'h7FFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 32'h7FFF_FFFF);
        push_req(FUNC_LOOKUP, 32'h8000_0001, 64'h0,                   1'b0, 32'h0);
        push_req(FUNC_LOOKUP, 32'h7FFF_FFFE, 64'h0,                   1'b0, 32'h0);
        push_req(FUNC_STORE,  32'h0000_0000, 64'h0,                   1'b1, 32'h0);
        push_req(FUNC_LOOKUP, 32'h0000_0000, '1,                      1'b1, 32'hFFFF_FFFF);
        push_req(FUNC_STORE,  32'h5555_5555, 64'h5555_5555_5555_5555, 1'b0, 32'h5555_5555);
        push_req(FUNC_LOOKUP, 32'h5555_5555, 64'h0,                   1'b0, 32'hAAAA_AAAA);
        push_req(FUNC_STORE,  32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 32'hAAAA_AAAA);
        push_req(FUNC_LOOKUP, 32'hAAAA_AAAA, 64'h0,                   1'b0, 32'h5555_5555);
        wait_drained();

        wall_clock = 32'd1000;
        add_random_reqs(500, 96);
        // sender stays quiet until every result is back
        wait_drained();

        // clock wraps during this phase
        wall_clock = 32'hFFFF_FF00;
        add_random_reqs(600, 80);
        hold_armed = 1'b1;
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge aclk);

        if (fail_count == 0 && rsp_owed.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // driver: bursts of words with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        logic nxt_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) rsp_owed = {rsp_owed, cache_access(s_data)};
            if (!(s_valid && !s_ready)) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_backlog.size() != 0) begin
                    nxt_valid = 1'b1;
                    s_data <= req_backlog.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(20, 1);
                        gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(30, 1);
                    end
                end
                s_valid <= nxt_valid;
            end
        end
    end

    // receiver stall pattern, plus one long hold while the sender keeps offering
    int         stall_left = 0;
    int         stall_mode = 0;
    int         hold_left  = 0;
    logic       hold_done  = 1'b0;
    logic [2:0] stall_phase = '0;

    always @(posedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (stall_left == 0) begin
                stall_left = $urandom_range(400, 50);
                stall_mode = $urandom_range(3, 0);
            end
            stall_left--;
            stall_phase = stall_phase + 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(1, 0);
                    2: rdy = ($urandom_range(7, 0) != 0);
                    default: rdy = stall_phase[2];
                endcase
            end
            m_ready <= rdy;
        end
    end

    // monitor
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_owed.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: hit=%0b payload=%h evicted=%0b key=%h",
                             m_data.hit, m_data.payload_out, m_data.evicted, m_data.evicted_key);
            end else begin
                want = rsp_owed.pop_front();
                if (m_data.hit !== want.hit || m_data.payload_out !== want.payload_out ||
                    m_data.evicted !== want.evicted || m_data.evicted_key !== want.evicted_key) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected hit=%0b payload=%h evicted=%0b key=%h",
                                 want.hit, want.payload_out, want.evicted, want.evicted_key);
                        $display("          actual   hit=%0b payload=%h evicted=%0b key=%h",
                                 m_data.hit, m_data.payload_out, m_data.evicted,
                                 m_data.evicted_key);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
